// ===== rtl/three_channel_16bit_timer_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef THREE_CHANNEL_16BIT_TIMER_UNIT_DEFINES_SVH
`define THREE_CHANNEL_16BIT_TIMER_UNIT_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define TCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define TCU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcu_pkg.sv =====
package tcu_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    // common register offsets (address[4:3] == 0)
    localparam logic [2:0] ADDR_START    = 3'd0;
    localparam logic [2:0] ADDR_SYNC     = 3'd1;
    localparam logic [2:0] ADDR_MODE     = 3'd2;
    localparam logic [2:0] ADDR_OLVL     = 3'd3;
    localparam logic [2:0] ADDR_STAT_A   = 3'd4;
    localparam logic [2:0] ADDR_STAT_B   = 3'd5;
    localparam logic [2:0] ADDR_STAT_OVF = 3'd6;

    // per-channel register offsets
    localparam logic [2:0] OFF_CTRL   = 3'd0;
    localparam logic [2:0] OFF_IOCTRL = 3'd1;
    localparam logic [2:0] OFF_CNT    = 3'd2;
    localparam logic [2:0] OFF_GRA    = 3'd4;
    localparam logic [2:0] OFF_GRB    = 3'd6;

    // status register kinds
    localparam int KIND_A   = 0;
    localparam int KIND_B   = 1;
    localparam int KIND_OVF = 2;
    localparam int NUM_KINDS = 3;

    // clear select codes
    localparam logic [1:0] CLR_GRA = 2'd1;
    localparam logic [1:0] CLR_GRB = 2'd2;

    // fixed one bits on read
    localparam logic [7:0] FIX_START  = 8'hF8;
    localparam logic [7:0] FIX_SYNC   = 8'hF8;
    localparam logic [7:0] FIX_MODE   = 8'h98;
    localparam logic [7:0] FIX_OLVL   = 8'hC0;
    localparam logic [7:0] FIX_STAT   = 8'h88;
    localparam logic [7:0] FIX_CTRL   = 8'h80;
    localparam logic [7:0] FIX_IOCTRL = 8'h88;

    localparam logic [15:0] RD_NONE_CH = 16'hFFFF;
    localparam logic [15:0] CNT_MAX    = 16'hFFFF;
    localparam logic [15:0] GR_RESET   = 16'hFFFF;

endpackage

// ===== rtl/tcu_if.sv =====
interface tcu_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [4:0]  reg_address;
    logic [15:0] write_data;

    modport source (output valid, opcode, reg_address, write_data, input ready);
    modport sink   (input valid, opcode, reg_address, write_data, output ready);
endinterface

interface tcu_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [11:0] irq_lines;

    modport source (output valid, read_data, irq_lines, input ready);
    modport sink   (input valid, read_data, irq_lines, output ready);
endinterface

// ===== rtl/three_channel_16bit_timer_unit.sv =====
// A response is written to the output register in the cycle after its request is accepted.
// Throughput: one request per cycle while no response is stalled; a request is taken while the previous response
// is being taken, since all work fits between the request and the output register.
// Reset (rst_n low, async): counters, prescaler and control registers clear,
// general registers go to 0xFFFF, no response is pending.
module three_channel_16bit_timer_unit #(
    parameter int NUM_CHANNELS = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    tcu_cmd_if.sink    cmd,
    tcu_rsp_if.source  rsp
);

    logic [2:0]  prescale_reg, prescale_next, prescale_inc;
    logic [7:0]  start_reg, start_next;
    logic [7:0]  sync_reg, sync_next;
    logic [7:0]  mode_reg, mode_next;
    logic [7:0]  olvl_reg, olvl_next;
    logic [7:0]  stat_reg [tcu_pkg::NUM_KINDS];
    logic [7:0]  stat_next [tcu_pkg::NUM_KINDS];
    logic [7:0]  ctrl_reg [NUM_CHANNELS];
    logic [7:0]  ctrl_next [NUM_CHANNELS];
    logic [7:0]  ioctrl_reg [NUM_CHANNELS];
    logic [7:0]  ioctrl_next [NUM_CHANNELS];
    logic [15:0] cnt_reg [NUM_CHANNELS];
    logic [15:0] cnt_next [NUM_CHANNELS];
    logic [15:0] gra_reg [NUM_CHANNELS];
    logic [15:0] gra_next [NUM_CHANNELS];
    logic [15:0] grb_reg [NUM_CHANNELS];
    logic [15:0] grb_next [NUM_CHANNELS];

    logic        valid_reg;
    logic [15:0] rdata_reg, rdata_next;
    logic [11:0] irq_reg, irq_next;

    logic [NUM_CHANNELS-1:0] tick_en, ovf_set, hit_a, hit_b, chan_sel;
    logic [15:0] cnt_step [NUM_CHANNELS];

    logic accept;
    logic common_sel;
    logic [2:0] offset;
    logic [7:0] wbyte;

    assign cmd.ready     = !valid_reg || rsp.ready;
    assign accept        = cmd.valid && cmd.ready;
    assign rsp.valid     = valid_reg;
    assign rsp.read_data = rdata_reg;
    assign rsp.irq_lines = irq_reg;

    assign common_sel   = cmd.reg_address[4:3] == 2'd0;
    assign offset       = cmd.reg_address[2:0];
    assign wbyte        = cmd.write_data[7:0];
    assign prescale_inc = prescale_reg + 3'd1;

    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_ch
        logic [2:0] sel;
        logic [1:0] clr;
        logic [2:0] div_mask;
        logic       clr_hit;
        logic       wrap;

        assign sel      = ctrl_reg[i][2:0];
        assign clr      = ctrl_reg[i][6:5];
        assign div_mask = 3'((4'd1 << sel[1:0]) - 4'd1);
        assign tick_en[i] = start_reg[i] && !sel[2] && ((prescale_inc & div_mask) == 3'd0);
        assign clr_hit  = (clr == tcu_pkg::CLR_GRA && cnt_reg[i] == gra_reg[i])
                       || (clr == tcu_pkg::CLR_GRB && cnt_reg[i] == grb_reg[i]);
        assign wrap     = cnt_reg[i] == tcu_pkg::CNT_MAX;
        assign cnt_step[i] = (clr_hit || wrap) ? 16'd0 : cnt_reg[i] + 16'd1;
        assign ovf_set[i]  = !clr_hit && wrap;
        assign hit_a[i]    = cnt_step[i] == gra_reg[i];
        assign hit_b[i]    = cnt_step[i] == grb_reg[i];
        assign chan_sel[i] = cmd.reg_address[4:3] == 2'(i + 1);
    end

    // state update
    always_comb
    begin
        prescale_next = prescale_reg;
        start_next    = start_reg;
        sync_next     = sync_reg;
        mode_next     = mode_reg;
        olvl_next     = olvl_reg;
        stat_next     = stat_reg;
        ctrl_next     = ctrl_reg;
        ioctrl_next   = ioctrl_reg;
        cnt_next      = cnt_reg;
        gra_next      = gra_reg;
        grb_next      = grb_reg;
        if (accept)
        begin
            unique case (tcu_pkg::op_t'(cmd.opcode))
                tcu_pkg::OP_TICK:
                begin
                    prescale_next = prescale_inc;
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        if (tick_en[i])
                        begin
                            cnt_next[i] = cnt_step[i];
                            if (ovf_set[i])
                                stat_next[tcu_pkg::KIND_OVF][i] = 1'b1;
                            if (hit_a[i])
                                stat_next[tcu_pkg::KIND_A][i] = 1'b1;
                            if (hit_b[i])
                                stat_next[tcu_pkg::KIND_B][i] = 1'b1;
                        end
                    end
                end
                tcu_pkg::OP_WRITE:
                begin
                    if (common_sel)
                    begin
                        unique case (offset)
                            tcu_pkg::ADDR_START: start_next = wbyte;
                            tcu_pkg::ADDR_SYNC:  sync_next  = wbyte;
                            tcu_pkg::ADDR_MODE:  mode_next  = wbyte;
                            tcu_pkg::ADDR_OLVL:  olvl_next  = wbyte;
                            tcu_pkg::ADDR_STAT_A, tcu_pkg::ADDR_STAT_B,
                            tcu_pkg::ADDR_STAT_OVF:
                                // enables replaced, flags cleared by writing zero
                                stat_next[offset[1:0]] = {1'b0, wbyte[6:4], 1'b0,
                                    stat_reg[offset[1:0]][2:0] & wbyte[2:0]};
                            default: ;
                        endcase
                    end
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        if (chan_sel[i])
                        begin
                            unique case (offset)
                                tcu_pkg::OFF_CTRL:   ctrl_next[i]   = wbyte;
                                tcu_pkg::OFF_IOCTRL: ioctrl_next[i] = wbyte;
                                tcu_pkg::OFF_CNT:    cnt_next[i]    = cmd.write_data;
                                tcu_pkg::OFF_GRA:    gra_next[i]    = cmd.write_data;
                                tcu_pkg::OFF_GRB:    grb_next[i]    = cmd.write_data;
                                default: ;
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // read data
    always_comb
    begin
        rdata_next = 16'd0;
        if (tcu_pkg::op_t'(cmd.opcode) == tcu_pkg::OP_READ)
        begin
            if (common_sel)
            begin
                unique case (offset)
                    tcu_pkg::ADDR_START: rdata_next = {8'd0, start_reg | tcu_pkg::FIX_START};
                    tcu_pkg::ADDR_SYNC:  rdata_next = {8'd0, sync_reg | tcu_pkg::FIX_SYNC};
                    tcu_pkg::ADDR_MODE:  rdata_next = {8'd0, mode_reg | tcu_pkg::FIX_MODE};
                    tcu_pkg::ADDR_OLVL:  rdata_next = {8'd0, olvl_reg | tcu_pkg::FIX_OLVL};
                    tcu_pkg::ADDR_STAT_A, tcu_pkg::ADDR_STAT_B, tcu_pkg::ADDR_STAT_OVF:
                        rdata_next = {8'd0, stat_reg[offset[1:0]] | tcu_pkg::FIX_STAT};
                    default: rdata_next = 16'd0;
                endcase
            end
            else
            begin
                rdata_next = tcu_pkg::RD_NONE_CH;
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (chan_sel[i])
                    begin
                        unique case (offset)
                            tcu_pkg::OFF_CTRL:
                                rdata_next = {8'd0, ctrl_reg[i] | tcu_pkg::FIX_CTRL};
                            tcu_pkg::OFF_IOCTRL:
                                rdata_next = {8'd0, ioctrl_reg[i] | tcu_pkg::FIX_IOCTRL};
                            tcu_pkg::OFF_CNT: rdata_next = cnt_reg[i];
                            tcu_pkg::OFF_GRA: rdata_next = gra_reg[i];
                            tcu_pkg::OFF_GRB: rdata_next = grb_reg[i];
                            default:          rdata_next = tcu_pkg::RD_NONE_CH;
                        endcase
                    end
                end
            end
        end
    end

    // interrupt lines from post-request flags
    always_comb
    begin
        irq_next = 12'd0;
        for (int k = 0; k < tcu_pkg::NUM_KINDS; k++)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                irq_next[i * 4 + k] = stat_next[k][i] && stat_next[k][i + 4];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= 3'd0;
            start_reg    <= 8'd0;
            sync_reg     <= 8'd0;
            mode_reg     <= 8'd0;
            olvl_reg     <= 8'd0;
            for (int k = 0; k < tcu_pkg::NUM_KINDS; k++)
                stat_reg[k] <= 8'd0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                ctrl_reg[i]   <= 8'd0;
                ioctrl_reg[i] <= 8'd0;
                cnt_reg[i]    <= 16'd0;
                gra_reg[i]    <= tcu_pkg::GR_RESET;
                grb_reg[i]    <= tcu_pkg::GR_RESET;
            end
            valid_reg <= 1'b0;
        end
        else
        begin
            prescale_reg <= prescale_next;
            start_reg    <= start_next;
            sync_reg     <= sync_next;
            mode_reg     <= mode_next;
            olvl_reg     <= olvl_next;
            stat_reg     <= stat_next;
            ctrl_reg     <= ctrl_next;
            ioctrl_reg   <= ioctrl_next;
            cnt_reg      <= cnt_next;
            gra_reg      <= gra_next;
            grb_reg      <= grb_next;
            if (accept)
                valid_reg <= 1'b1;
            else if (rsp.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

endmodule

// ===== rtl/tcu_checker.sv =====
`include "three_channel_16bit_timer_unit_defines.svh"

module tcu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic [1:0]  opcode,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] read_data,
    input logic [11:0] irq_lines
);

    `TCU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(read_data) && $stable(irq_lines), "response changed while stalled")
    `TCU_ASSERT_NEXT(a_req_to_rsp, cmd_valid && cmd_ready, rsp_valid, "accepted request gave no response")
    `TCU_ASSERT_NEXT(a_nonread_zero, cmd_valid && cmd_ready && opcode != tcu_pkg::OP_READ, read_data == 16'd0, "nonzero read data for non-read request")
    `TCU_ASSERT_SAME(a_irq_gap, rsp_valid, !irq_lines[3] && !irq_lines[7] && !irq_lines[11], "unused interrupt bit set")

endmodule

bind three_channel_16bit_timer_unit tcu_checker u_tcu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .opcode    (cmd.opcode),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .read_data (rsp.read_data),
    .irq_lines (rsp.irq_lines)
);
